/* rtl/nrdiv_pkg.sv */
// Shared types and constants for the non-restoring integer divider.
// No dependencies; used by every module of the block.
`default_nettype none

package nrdiv_pkg;

    // Default operand width
    localparam int WIDTH_DEF = 16;

    // Control that travels alongside each request through the stages
    typedef struct packed {
        logic valid;
        logic dz;
    } ctl_t;

endpackage : nrdiv_pkg

`default_nettype wire

/* rtl/nrdiv_stage.sv */
// One pipeline stage of the non-restoring divider: a single add/subtract step.
// Depends on nrdiv_pkg (ctl_t).
`default_nettype none

module nrdiv_stage #(
    parameter int WIDTH = nrdiv_pkg::WIDTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire nrdiv_pkg::ctl_t    ctl_in,
    input  wire logic [WIDTH+1:0]   rem_in,
    input  wire logic [WIDTH-1:0]   quo_in,
    input  wire logic [WIDTH-1:0]   dsr_in,
    output nrdiv_pkg::ctl_t         ctl_out,
    output logic      [WIDTH+1:0]   rem_out,
    output logic      [WIDTH-1:0]   quo_out,
    output logic      [WIDTH-1:0]   dsr_out
);

    nrdiv_pkg::ctl_t  ctl_reg;
    logic [WIDTH+1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] dsr_reg;
    logic [WIDTH+1:0] shifted;
    logic [WIDTH+1:0] dsr_ext;

    // Shift next dividend bit into the partial remainder, then add or subtract
    // the divisor depending on the remainder's sign.
    always_comb
    begin
        shifted = {rem_in[WIDTH:0], quo_in[WIDTH-1]};
        dsr_ext = {2'b00, dsr_in};
        if (rem_in[WIDTH+1])
        begin
            rem_next = shifted + dsr_ext;
        end
        else
        begin
            rem_next = shifted - dsr_ext;
        end
        quo_next = {quo_in[WIDTH-2:0], ~rem_next[WIDTH+1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            dsr_reg <= dsr_in;
        end
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign quo_out = quo_reg;
    assign dsr_out = dsr_reg;

endmodule : nrdiv_stage

`default_nettype wire

/* rtl/nonrestoring_integer_divider_top.sv */
// The WIDTH step stages (WIDTH is 16 by default) form a linear pipeline.
// Throughput: one request per cycle, unless a held result stalls the pipeline.
// A stalled result freezes the whole pipeline, so req_stall follows rsp_stall.
// Reset (rst_n, asynchronous, active low) clears all stage valid bits.
// Depends on nrdiv_pkg and nrdiv_stage.
`default_nettype none

module nonrestoring_integer_divider_top #(
    parameter int WIDTH = nrdiv_pkg::WIDTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    // request channel
    input  wire logic             req_valid,
    output logic                  req_stall,
    input  wire logic [WIDTH-1:0] dividend,
    input  wire logic [WIDTH-1:0] divisor,
    // result channel
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output logic      [WIDTH-1:0] quotient,
    output logic                  div_by_zero
);

    // Per-stage buses; index 0 is the request port, index k is stage k output.
    nrdiv_pkg::ctl_t  ctl  [WIDTH+1];
    logic [WIDTH+1:0] rem  [WIDTH+1];
    logic [WIDTH-1:0] quo  [WIDTH+1];
    logic [WIDTH-1:0] dsr  [WIDTH+1];
    logic             en;

    // The pipeline moves unless a finished result is held by the consumer.
    assign en        = !(rsp_valid && rsp_stall);
    assign req_stall = !en;

    // Request enters with a zero partial remainder; the dividend sits in the
    // quotient register and is shifted out one bit per stage.
    assign ctl[0].valid = req_valid;
    assign ctl[0].dz    = (divisor == '0);
    assign rem[0]       = '0;
    assign quo[0]       = dividend;
    assign dsr[0]       = divisor;

    // One non-restoring step per stage, WIDTH stages in all.
    for (genvar k = 0; k < WIDTH; k++)
    begin : g_stage
        nrdiv_stage #(
            .WIDTH (WIDTH)
        ) u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .ctl_in  (ctl[k]),
            .rem_in  (rem[k]),
            .quo_in  (quo[k]),
            .dsr_in  (dsr[k]),
            .ctl_out (ctl[k+1]),
            .rem_out (rem[k+1]),
            .quo_out (quo[k+1]),
            .dsr_out (dsr[k+1])
        );
    end

    // Quotient bits equal those of true division; a zero divisor forces zero.
    assign rsp_valid   = ctl[WIDTH].valid;
    assign div_by_zero = ctl[WIDTH].dz;
    assign quotient    = ctl[WIDTH].dz ? '0 : quo[WIDTH];

endmodule : nonrestoring_integer_divider_top

`default_nettype wire

/* rtl/nrdiv_checker.sv */
// Port-level checks for the divider top level, bound in below.
// Depends on nrdiv_pkg (WIDTH_DEF) and on nonrestoring_integer_divider_top's port list.
`default_nettype none

module nrdiv_checker #(
    parameter int WIDTH = nrdiv_pkg::WIDTH_DEF
) (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             req_valid,
    input wire logic             req_stall,
    input wire logic [WIDTH-1:0] dividend,
    input wire logic [WIDTH-1:0] divisor,
    input wire logic             rsp_valid,
    input wire logic             rsp_stall,
    input wire logic [WIDTH-1:0] quotient,
    input wire logic             div_by_zero
);

    // Stalled request stays offered with the same operands
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(dividend) && $stable(divisor))
        else $error("request changed while stalled");

    // Held result stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("result dropped while stalled");

    // Held result payload does not change
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(quotient) && $stable(div_by_zero))
        else $error("result changed while stalled");

    // Division by zero reports a zero quotient
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && div_by_zero |-> quotient == '0)
        else $error("non-zero quotient on divide by zero");

    // Requests are only held off by a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid && rsp_stall)
        else $error("request stalled without back-pressure");

endmodule : nrdiv_checker

bind nonrestoring_integer_divider_top nrdiv_checker #(
    .WIDTH (WIDTH)
) u_nrdiv_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .dividend    (dividend),
    .divisor     (divisor),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .quotient    (quotient),
    .div_by_zero (div_by_zero)
);

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the unsigned non-restoring integer divider.
// Depends on nrdiv_pkg and nonrestoring_integer_divider_top; no files read.
`timescale 1ns / 100ps

module tb_top;

    localparam int W          = nrdiv_pkg::WIDTH_DEF;
    localparam int HOLD_LEN   = 90;      // long receiver hold, well past pipeline depth
    localparam int DRAIN_WAIT = 2 * W + 8;
    localparam int CYCLE_CAP  = 300000;  // watchdog limit, in clock cycles

    typedef struct {
        logic [W-1:0] quotient;
        logic         dz;
    } quot_rec_t;

    logic         clk;
    logic         rst_n;
    logic         req_valid;
    logic         req_stall;
    logic [W-1:0] dividend;
    logic [W-1:0] divisor;
    logic         rsp_valid;
    logic         rsp_stall;
    logic [W-1:0] quotient;
    logic         div_by_zero;

    // Expected quotients, oldest first
    quot_rec_t    pending_quots[$];
    int           n_errors;
    int           n_cycles;

    // Idle controls: the sender's is read only by its own thread, the
    // receiver's is written with NBAs so the sink sees a settled value.
    bit           src_idle;
    bit           sink_idle;
    int unsigned  hold_token;

    nonrestoring_integer_divider_top #(
        .WIDTH (W)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .dividend    (dividend),
        .divisor     (divisor),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .quotient    (quotient),
        .div_by_zero (div_by_zero)
    );

    // 4 ns period
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_CAP)
        begin
            $display("%0t: timeout after %0d cycles", $time, n_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // Quotient predictor, worked step by step in non-restoring form:
    // align the divisor by the difference of significant-bit lengths, take
    // the leading bit from a plain subtraction, then per step double the
    // partial remainder and add or subtract the aligned divisor by its sign.
    function automatic quot_rec_t predict_quotient(input logic [W-1:0] a,
                                                   input logic [W-1:0] d);
        quot_rec_t r;
        int        shift;
        int        i;
        longint    aligned;
        longint    rem;
        logic [W-1:0] q;
        r.quotient = '0;
        r.dz       = 1'b0;
        if (d == '0)
        begin
            r.dz = 1'b1;
            return r;
        end
        shift = $clog2(longint'(a) + 1) - $clog2(longint'(d) + 1);
        if (shift < 0)
            return r;
        aligned = longint'(d) << shift;
        rem     = longint'(a) - aligned;
        q       = (rem < 0) ? '0 : W'(1);
        for (i = 0; i < shift; i++)
        begin
            rem = rem * 2;
            if (rem < 0)
                rem = rem + aligned;
            else
                rem = rem - aligned;
            q = {q[W-2:0], (rem >= 0)};
        end
        r.quotient = q;
        return r;
    endfunction

    // Operand with a random significant-bit length, so that every alignment
    // distance gets exercised rather than mostly full-width values.
    function automatic logic [W-1:0] rand_operand();
        int           len;
        logic [W-1:0] v;
        logic [W-1:0] one;
        one = W'(1);
        len = $urandom_range(0, W);
        v   = W'($urandom);
        v   = v & ((one << len) - one);
        if (len > 0)
            v[len-1] = 1'b1;
        return v;
    endfunction

    // Offer one request and wait for it to be taken. The stall is sampled on
    // the falling edge, where nothing driven at the rising edge is in flight.
    task automatic send_request(input logic [W-1:0] a, input logic [W-1:0] d);
        int gap;
        bit taken;
        if (src_idle && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            gap = $urandom_range(1, 15);
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        dividend  <= a;
        divisor   <= d;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !req_stall;
            if (taken)
                pending_quots.push_back(predict_quotient(a, d));
            @(posedge clk);
        end
    endtask

    // Result checker: a result is taken at the next rising edge when valid
    // and not stalled, and both are stable by the falling edge.
    always @(negedge clk)
    begin : result_check
        quot_rec_t want;
        if (rst_n === 1'b1 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            if (pending_quots.size() == 0)
            begin
                $display("%0t: unexpected result quotient=%0h div_by_zero=%0b",
                         $time, quotient, div_by_zero);
                n_errors++;
            end
            else
            begin
                want = pending_quots.pop_front();
                if (quotient !== want.quotient)
                begin
                    $display("%0t: quotient expected %0h actual %0h",
                             $time, want.quotient, quotient);
                    n_errors++;
                end
                if (div_by_zero !== want.dz)
                begin
                    $display("%0t: div_by_zero expected %0b actual %0b",
                             $time, want.dz, div_by_zero);
                    n_errors++;
                end
            end
        end
    end

    // Receiver: random stall bursts, plus a long hold on request from a test.
    // The hold is counted here so the sender keeps offering meanwhile.
    initial
    begin : sink
        int unsigned seen;
        int          n;
        int          burst;
        seen      = 0;
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_token != seen)
            begin
                seen = hold_token;
                rsp_stall <= 1'b1;
                for (n = 0; n < HOLD_LEN; n++)
                    @(posedge clk);
                rsp_stall <= 1'b0;
            end
            else if (sink_idle && $urandom_range(0, 4) == 0)
            begin
                rsp_stall <= 1'b1;
                burst = $urandom_range(1, 15);
                repeat (burst) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // Field extremes and single-bit operands
    task automatic test_extremes();
        send_request('0, '0);
        send_request('1, '1);
        send_request('1, W'(1));
        send_request('0, '1);
        send_request(W'(1), '1);
        send_request(W'(1), W'(1));
        send_request({1'b1, {(W-1){1'b0}}}, W'(1));
        send_request({1'b1, {(W-1){1'b0}}}, {1'b1, {(W-1){1'b0}}});
        send_request('1, W'(2));
        send_request({(W/4){4'hA}}, {(W/4){4'h5}});
        send_request({(W/4){4'h5}}, {(W/4){4'hA}});
    endtask

    // Zero divisor, divisor longer than dividend, zero dividend, and the case
    // where the first subtraction goes negative at equal lengths
    task automatic test_special_cases();
        send_request(W'(16'h1234), '0);
        send_request('1, '0);
        send_request('0, W'(7));
        send_request({1'b0, {(W-1){1'b1}}}, {1'b1, {(W-1){1'b0}}});
        send_request(W'(3), W'(4));
        send_request({1'b1, {(W-1){1'b0}}}, '1);
        send_request(W'(100), W'(7));
        send_request(W'(5), W'(3));
        send_request(W'(12), W'(3));
        send_request(W'(16'h7FFF), W'(16'h00FF));
        send_request('0, '0);
    endtask

    // Bulk random requests with a spread of alignment distances
    task automatic test_random_mix(input int count);
        int i;
        int pick;
        for (i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                send_request(rand_operand(), '0);
            else if (pick == 1)
                send_request(W'($urandom), W'($urandom));
            else
                send_request(rand_operand(), rand_operand());
        end
    endtask

    // Receiver holds off while the sender keeps going, so the pipeline fills
    // and the stall reaches the request side.
    task automatic test_backpressure();
        src_idle = 1'b0;
        hold_token <= hold_token + 1;
        test_random_mix(60);
        src_idle = 1'b1;
    endtask

    // Back-to-back at full rate, no idling on either side
    task automatic test_full_rate();
        src_idle = 1'b0;
        sink_idle <= 1'b0;
        test_random_mix(100);
        req_valid <= 1'b0;
    endtask

    initial
    begin
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        dividend   = '0;
        divisor    = '0;
        n_errors   = 0;
        n_cycles   = 0;
        hold_token = 0;
        src_idle   = 1'b1;
        sink_idle  = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_special_cases();
        test_random_mix(340);
        test_backpressure();
        test_random_mix(330);
        test_full_rate();

        // Drain, then allow for anything stray still in the pipe
        while (pending_quots.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (n_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
